// File: sv/mos_pkg.sv
// Package with the shared types, constants and time helpers of the OnOff server.
package mos_pkg;

  localparam int unsigned TIME_WIDTH = 26;
  localparam int unsigned DIV_W      = TIME_WIDTH + 1;
  localparam int unsigned RES_W      = 20;
  localparam int unsigned PROD_W     = 6 + RES_W;
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);
  localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);

  localparam int unsigned MS_PER_SECOND = 1000;
  localparam int unsigned DELAY_UNIT_MS = 5;
  localparam int unsigned STEP_MAX      = 62;
  localparam logic [5:0]  STEP_FOREVER  = 6'h3f;
  localparam logic [7:0]  CODE_FOREVER  = 8'h3f;
  localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_GET       = 2'd1,
    CMD_SET_ACK   = 2'd2,
    CMD_SET_UNACK = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SUM,
    B_PICK,
    B_DIV
  } back_state_e;

  typedef struct packed {
    cmd_e                  cmd;
    logic                  value;
    logic [7:0]            tid;
    logic [15:0]           src;
    logic                  forever_flag;
    logic [TIME_WIDTH-1:0] trans;
    logic [TIME_WIDTH-1:0] delay;
  } item_t;

  typedef struct packed {
    logic valid;
    logic pop;
  } q_ctrl_t;

  function automatic logic [RES_W-1:0] res_ms(input logic [1:0] idx);
    logic [RES_W-1:0] r;
    case (idx)
      2'd0: r = RES_W'(100);
      2'd1: r = RES_W'(MS_PER_SECOND);
      2'd2: r = RES_W'(10 * MS_PER_SECOND);
      2'd3: r = RES_W'(10 * 60 * MS_PER_SECOND);
      default: r = RES_W'(100);
    endcase
    return r;
  endfunction

  function automatic logic [TIME_WIDTH-1:0] res_limit(input logic [1:0] idx);
    logic [TIME_WIDTH-1:0] r;
    r = TIME_WIDTH'(res_ms(idx));
    return TIME_WIDTH'(r * TIME_WIDTH'(STEP_MAX));
  endfunction

endpackage

// File: sv/mos_front.sv
// Front end that accepts requests and decodes their transition and delay times.
module mos_front import mos_pkg::*; (
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic        new_value_i,
  input  logic [7:0]  trans_id_i,
  input  logic [15:0] source_addr_i,
  input  logic        has_timing_i,
  input  logic [7:0]  transition_code_i,
  input  logic [7:0]  delay_steps_i,
  input  logic        q_full_i,
  output logic        push_o,
  output item_t       item_o
);

  logic [5:0]        steps;
  logic [PROD_W-1:0] trans_prod;
  logic [10:0]       delay_prod;
  logic              is_forever;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    steps      = transition_code_i[5:0];
    is_forever = has_timing_i && (steps == STEP_FOREVER);
    trans_prod = PROD_W'(steps) * PROD_W'(res_ms(transition_code_i[7:6]));
    delay_prod = 11'(delay_steps_i) * 11'(DELAY_UNIT_MS);

    item_o.cmd          = cmd_e'(cmd_i);
    item_o.value        = new_value_i;
    item_o.tid          = trans_id_i;
    item_o.src          = source_addr_i;
    item_o.forever_flag = is_forever;
    item_o.trans        = (has_timing_i && !is_forever) ? TIME_WIDTH'(trans_prod) : '0;
    item_o.delay        = has_timing_i ? TIME_WIDTH'(delay_prod) : '0;
  end

endmodule

// File: sv/mos_queue.sv
// Short request queue between the front end and the execution back end.
module mos_queue import mos_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  item_t   item_i,
  output logic    full_o,
  input  q_ctrl_t ctrl_i,
  output logic    valid_o,
  output item_t   item_o
);

  item_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_pop  = ctrl_i.pop && ctrl_i.valid;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// File: sv/mos_back.sv
// Back end that updates the server state, runs the timer and encodes the status.
module mos_back import mos_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  item_t      item_i,
  output q_ctrl_t    q_ctrl_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       status_valid_o,
  output logic       present_value_o,
  output logic       target_out_o,
  output logic       has_remaining_o,
  output logic [7:0] remaining_code_o,
  output logic       led_on_o
);

  back_state_e state_q, state_d;

  logic                  onoff_q, onoff_d;
  logic [7:0]            tid_q, tid_d;
  logic [15:0]           src_q, src_d;
  logic [TIME_WIDTH-1:0] pend_q, pend_d;
  logic                  forever_q, forever_d;
  logic [TIME_WIDTH-1:0] timer_q, timer_d;
  logic                  armed_q, armed_d;
  logic                  led_q, led_d;

  logic [TIME_WIDTH-1:0] rem_q, rem_d;
  logic [1:0]            idx_q, idx_d;
  logic [DIV_W-1:0]      p_q, p_d;
  logic [DIV_W-1:0]      dv_q, dv_d;
  logic [5:0]            quo_q, quo_d;
  logic [1:0]            step_q, step_d;

  logic       ov_q, ov_d;
  logic       sv_q, sv_d;
  logic       pv_q, pv_d;
  logic       tv_q, tv_d;
  logic       hr_q, hr_d;
  logic [7:0] code_q, code_d;
  logic       lo_q, lo_d;

  logic                  out_free;
  logic                  pop;
  logic [TIME_WIDTH-1:0] timer_dec;
  logic [TIME_WIDTH:0]   sum;
  logic                  found;
  logic [1:0]            sel_idx;
  logic [DIV_W+1:0]      pe, d1, d2, d3, sub;
  logic [1:0]            digit;
  logic [DIV_W-1:0]      res_w;

  assign out_free         = !ov_q || !out_stall_i;
  assign q_ctrl_o.valid   = q_valid_i;
  assign q_ctrl_o.pop     = pop;
  assign out_valid_o      = ov_q;
  assign status_valid_o   = sv_q;
  assign present_value_o  = pv_q;
  assign target_out_o     = tv_q;
  assign has_remaining_o  = hr_q;
  assign remaining_code_o = code_q;
  assign led_on_o         = lo_q;
  assign timer_dec        = timer_q - TIME_WIDTH'(1);

  always_comb begin
    state_d   = state_q;
    onoff_d   = onoff_q;
    tid_d     = tid_q;
    src_d     = src_q;
    pend_d    = pend_q;
    forever_d = forever_q;
    timer_d   = timer_q;
    armed_d   = armed_q;
    led_d     = led_q;
    rem_d     = rem_q;
    idx_d     = idx_q;
    p_d       = p_q;
    dv_d      = dv_q;
    quo_d     = quo_q;
    step_d    = step_q;
    ov_d      = ov_q && out_stall_i;
    sv_d      = sv_q;
    pv_d      = pv_q;
    tv_d      = tv_q;
    hr_d      = hr_q;
    code_d    = code_q;
    lo_d      = lo_q;
    pop       = 1'b0;
    sum       = '0;
    found     = 1'b0;
    sel_idx   = 2'd0;
    pe        = '0;
    d1        = '0;
    d2        = '0;
    d3        = '0;
    sub       = '0;
    digit     = 2'd0;
    res_w     = '0;

    case (state_q)
      B_IDLE: begin
        if (q_valid_i && out_free) begin
          pop = 1'b1;
          case (item_i.cmd)
            CMD_TICK: begin
              if (armed_q) begin
                if (timer_q == '0 || timer_dec == '0) begin
                  if (forever_q) begin
                    led_d   = 1'b1;
                    armed_d = 1'b0;
                    timer_d = '0;
                  end else if (pend_q != '0) begin
                    led_d   = 1'b1;
                    timer_d = pend_q;
                    pend_d  = '0;
                    armed_d = 1'b1;
                  end else begin
                    led_d   = onoff_q;
                    armed_d = 1'b0;
                    timer_d = '0;
                  end
                end else begin
                  timer_d = timer_dec;
                end
              end
            end
            CMD_SET_ACK, CMD_SET_UNACK: begin
              if (!(item_i.tid == tid_q && item_i.src == src_q) &&
                  item_i.value != onoff_q) begin
                tid_d     = item_i.tid;
                src_d     = item_i.src;
                onoff_d   = item_i.value;
                pend_d    = item_i.trans;
                forever_d = item_i.forever_flag;
                timer_d   = item_i.delay;
                armed_d   = 1'b1;
              end
            end
            default: begin
            end
          endcase
          if (item_i.cmd == CMD_GET || item_i.cmd == CMD_SET_ACK) begin
            state_d = B_SUM;
          end else begin
            ov_d   = 1'b1;
            sv_d   = 1'b0;
            pv_d   = 1'b0;
            tv_d   = 1'b0;
            hr_d   = 1'b0;
            code_d = '0;
            lo_d   = led_d;
          end
        end
      end
      B_SUM: begin
        sum     = {1'b0, (armed_q ? timer_q : TIME_WIDTH'(0))} + {1'b0, pend_q};
        rem_d   = sum[TIME_WIDTH] ? TIME_MAX : sum[TIME_WIDTH-1:0];
        state_d = B_PICK;
      end
      B_PICK: begin
        for (int i = 3; i >= 0; i--) begin
          if (rem_q <= res_limit(2'(i))) begin
            found   = 1'b1;
            sel_idx = 2'(i);
          end
        end
        res_w = DIV_W'(res_ms(sel_idx));
        sv_d  = 1'b1;
        lo_d  = led_q;
        if (forever_q || rem_q == '0 || !found) begin
          ov_d    = 1'b1;
          hr_d    = forever_q || rem_q != '0;
          pv_d    = hr_d ? !onoff_q : onoff_q;
          tv_d    = hr_d ? onoff_q : 1'b0;
          code_d  = hr_d ? CODE_FOREVER : '0;
          state_d = B_IDLE;
        end else begin
          idx_d   = sel_idx;
          p_d     = DIV_W'(rem_q) + res_w - DIV_W'(1);
          dv_d    = res_w << 4;
          quo_d   = '0;
          step_d  = 2'd0;
          state_d = B_DIV;
        end
      end
      B_DIV: begin
        pe = {2'b00, p_q};
        d1 = {2'b00, dv_q};
        d2 = d1 << 1;
        d3 = d2 + d1;
        if (pe >= d3) begin
          digit = 2'd3;
          sub   = d3;
        end else if (pe >= d2) begin
          digit = 2'd2;
          sub   = d2;
        end else if (pe >= d1) begin
          digit = 2'd1;
          sub   = d1;
        end
        p_d    = DIV_W'(pe - sub);
        dv_d   = dv_q >> 2;
        quo_d  = {quo_q[3:0], digit};
        step_d = step_q + 2'd1;
        if (step_q == 2'd2) begin
          ov_d    = 1'b1;
          hr_d    = 1'b1;
          pv_d    = !onoff_q;
          tv_d    = onoff_q;
          code_d  = {idx_q, quo_d};
          state_d = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      onoff_q   <= 1'b0;
      tid_q     <= '0;
      src_q     <= '0;
      pend_q    <= '0;
      forever_q <= 1'b0;
      timer_q   <= '0;
      armed_q   <= 1'b0;
      led_q     <= 1'b0;
      ov_q      <= 1'b0;
      step_q    <= '0;
    end else begin
      state_q   <= state_d;
      onoff_q   <= onoff_d;
      tid_q     <= tid_d;
      src_q     <= src_d;
      pend_q    <= pend_d;
      forever_q <= forever_d;
      timer_q   <= timer_d;
      armed_q   <= armed_d;
      led_q     <= led_d;
      ov_q      <= ov_d;
      step_q    <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    idx_q  <= idx_d;
    p_q    <= p_d;
    dv_q   <= dv_d;
    quo_q  <= quo_d;
    sv_q   <= sv_d;
    pv_q   <= pv_d;
    tv_q   <= tv_d;
    hr_q   <= hr_d;
    code_q <= code_d;
    lo_q   <= lo_d;
  end

endmodule

// File: sv/mesh_onoff_server_top.sv
// Top level of the Generic OnOff server: front end, request queue and back end.
//
//  Channel | Handshake              | Payload
//  --------+------------------------+---------------------------------------------------
//  in      | in_valid_i, in_stall_o | cmd, new_value, trans_id, source_addr, has_timing,
//          |                        | transition_code, delay_steps
//  out     | out_valid_o,out_stall_i| status_valid, present_value, target_out,
//          |                        | has_remaining, remaining_code, led_on
//
// Ticks and unacknowledged sets are finished in the accept state. Gets and acknowledged
// sets pass through accept, sum and resolution, and then through three radix-4 steps
// of the constant divider when the remaining time needs a division.
// A four-entry queue lets the front accept requests while the back end works.
// Reset clears the server state, the queue and the output valid flag at once.
// A stalled output holds its result while further requests fill the queue.
module mesh_onoff_server_top import mos_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic        new_value_i,
  input  logic [7:0]  trans_id_i,
  input  logic [15:0] source_addr_i,
  input  logic        has_timing_i,
  input  logic [7:0]  transition_code_i,
  input  logic [7:0]  delay_steps_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_valid_o,
  output logic        present_value_o,
  output logic        target_out_o,
  output logic        has_remaining_o,
  output logic [7:0]  remaining_code_o,
  output logic        led_on_o
);

  logic    push;
  logic    q_full;
  logic    q_valid;
  item_t   front_item;
  item_t   head_item;
  q_ctrl_t q_ctrl;

  mos_front u_front (
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .cmd_i             (cmd_i),
    .new_value_i       (new_value_i),
    .trans_id_i        (trans_id_i),
    .source_addr_i     (source_addr_i),
    .has_timing_i      (has_timing_i),
    .transition_code_i (transition_code_i),
    .delay_steps_i     (delay_steps_i),
    .q_full_i          (q_full),
    .push_o            (push),
    .item_o            (front_item)
  );

  mos_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .ctrl_i  (q_ctrl),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  mos_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .item_i           (head_item),
    .q_ctrl_o         (q_ctrl),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_valid_o   (status_valid_o),
    .present_value_o  (present_value_o),
    .target_out_o     (target_out_o),
    .has_remaining_o  (has_remaining_o),
    .remaining_code_o (remaining_code_o),
    .led_on_o         (led_on_o)
  );

endmodule

// File: sv/mos_checker.sv
// Port-level checker for the OnOff server and its bind to the top level.
module mos_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       status_valid_o,
  input logic       present_value_o,
  input logic       target_out_o,
  input logic       has_remaining_o,
  input logic [7:0] remaining_code_o
);

  a_reset_idle: assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_o)
    else $error("Output is valid right after reset.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(remaining_code_o))
    else $error("Stalled result changed.");

  a_no_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !status_valid_o |->
      !present_value_o && !target_out_o && !has_remaining_o && remaining_code_o == 8'd0)
    else $error("Result without status carries status fields.");

  a_plain_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_valid_o && !has_remaining_o |->
      !target_out_o && remaining_code_o == 8'd0)
    else $error("Status without remaining time carries a target or code.");

  a_transition: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_remaining_o |-> status_valid_o && present_value_o != target_out_o)
    else $error("Status in transition reports present equal to target.");

endmodule

bind mesh_onoff_server_top mos_checker u_mos_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .status_valid_o   (status_valid_o),
  .present_value_o  (present_value_o),
  .target_out_o     (target_out_o),
  .has_remaining_o  (has_remaining_o),
  .remaining_code_o (remaining_code_o)
);
